[hdl/rdct_pkg.sv]
// ----------------------------------------------------------------------------
// rdct_pkg: shared definitions for the reload down-counter timer
// Item and result types, register map, control bits and ID bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package rdct_pkg;

   localparam int COUNT_BITS = 32;

   typedef enum logic [2:0] {
      MODE_READ   = 3'd0,
      MODE_WRITE  = 3'd1,
      MODE_TICK   = 3'd2,
      MODE_SAMPLE = 3'd3,
      MODE_RESET  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      RESP_OK       = 2'd0,
      RESP_BAD_LEN  = 2'd1,
      RESP_BE_ERR   = 2'd2,
      RESP_ADDR_ERR = 2'd3
   } resp_type;

   localparam logic [11:0] ADDR_CTRL      = 12'h000;
   localparam logic [11:0] ADDR_VALUE     = 12'h004;
   localparam logic [11:0] ADDR_RELOAD    = 12'h008;
   localparam logic [11:0] ADDR_INTSTATUS = 12'h00C;
   localparam logic [11:0] ADDR_ID_FIRST  = 12'hFD0;
   localparam logic [11:0] ADDR_ID_LAST   = 12'hFFC;

   localparam int CTL_ENABLE  = 0;
   localparam int CTL_EXT_EN  = 1;
   localparam int CTL_EXT_CLK = 2;
   localparam int CTL_INT_EN  = 3;

   localparam logic [3:0] LEN_WORD  = 4'd4;
   localparam logic [3:0] LEN_DWORD = 4'd8;

   // packed with the first field in the highest bits
   typedef struct packed {
      logic        ext_level;
      logic [3:0]  stream_width;
      logic        byte_enables_used;
      logic [3:0]  transfer_length;
      logic [31:0] write_data;
      logic [11:0] address;
   } item_type;

   typedef struct packed {
      logic        interrupt_line;
      logic [31:0] read_data;
      resp_type    response;
   } result_type;

   // PID4..PID7, PID0..PID3, CID0..CID3 in address order
   function automatic logic [7:0] id_byte(input logic [3:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h04;
         4'd1:    b = 8'h00;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'h00;
         4'd4:    b = 8'h22;
         4'd5:    b = 8'hB8;
         4'd6:    b = 8'h1B;
         4'd7:    b = 8'h00;
         4'd8:    b = 8'h0D;
         4'd9:    b = 8'hF0;
         4'd10:   b = 8'h05;
         4'd11:   b = 8'hB1;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[hdl/reload_down_counter_timer_top.sv]
// ----------------------------------------------------------------------------
// reload_down_counter_timer_top: memory-mapped reload down-counter timer
// Stream front end around the timer core with a registered result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each req beat carries one bus read, bus write, internal tick, external
//   input sample or soft reset, selected by req_tuser. Every req beat yields
//   exactly one rsp beat with the access status, read data and the level of
//   the interrupt line after that beat.
//   The rsp beat is valid in the cycle after the req beat is taken.
//   Throughput is one beat per cycle while the receiver takes each rsp beat;
//   the core decodes and updates its registers in a single pass between the
//   req handshake and the result register.
//   When the receiver stalls, the result register holds its beat and
//   req_tready stays high only if that beat is taken in the same cycle.
//   Reset clears all timer registers and the result register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module reload_down_counter_timer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [11:0] address, [43:12] write_data, [47:44] transfer_length,
   // [48] byte_enables_used, [52:49] stream_width, [53] ext_level
   input  wire logic [55:0] req_tdata,
   // [2:0] mode
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] response, [33:2] read_data, [34] interrupt_line
   output logic [39:0]      rsp_tdata
);
   import rdct_pkg::*;

   logic       fire;
   item_type   item;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign item       = item_type'(req_tdata[53:0]);

   rdct_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .mode   (mode_type'(req_tuser)),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff};

endmodule

`default_nettype wire

[hdl/rdct_core.sv]
// ----------------------------------------------------------------------------
// rdct_core: timer register file and counter
// Holds control, value, reload, status and interrupt state; decodes one beat
// and produces its result combinationally, updating state when fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rdct_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  rdct_pkg::mode_type       mode,
   input  rdct_pkg::item_type       item,
   output rdct_pkg::result_type     result
);
   import rdct_pkg::*;

   logic [3:0]            control_ff, control_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] reload_ff, reload_in;
   logic                  status_ff, status_in;
   logic                  int_ff, int_in;
   logic                  last_ext_ff, last_ext_in;

   logic                  do_count;
   logic                  len_bad;
   logic                  be_bad;
   logic                  id_hit;
   logic [11:0]           id_offs;
   logic [COUNT_BITS-1:0] write_cnt;

   assign len_bad   = (item.transfer_length != LEN_WORD) &&
                      (item.transfer_length != LEN_DWORD);
   assign be_bad    = item.byte_enables_used ||
                      ((item.stream_width != 4'd0) &&
                       (item.stream_width < item.transfer_length));
   assign id_offs   = item.address - ADDR_ID_FIRST;
   assign id_hit    = (item.address >= ADDR_ID_FIRST) && (item.address <= ADDR_ID_LAST) &&
                      (item.address[1:0] == 2'b00);
   assign write_cnt = item.write_data[COUNT_BITS-1:0];

   always_comb begin
      control_in      = control_ff;
      count_in        = count_ff;
      reload_in       = reload_ff;
      status_in       = status_ff;
      int_in          = int_ff;
      last_ext_in     = last_ext_ff;
      do_count        = 1'b0;
      result.response = RESP_OK;
      result.read_data = 32'd0;

      unique case (mode)
         MODE_READ, MODE_WRITE: begin
            if (len_bad) begin
               result.response = RESP_BAD_LEN;
            end else if (be_bad) begin
               result.response = RESP_BE_ERR;
            end else if (mode == MODE_READ) begin
               priority if (item.address == ADDR_CTRL) begin
                  result.read_data = 32'(control_ff);
               end else if (item.address == ADDR_VALUE) begin
                  result.read_data = 32'(count_ff);
               end else if (item.address == ADDR_RELOAD) begin
                  result.read_data = 32'(reload_ff);
               end else if (item.address == ADDR_INTSTATUS) begin
                  result.read_data = 32'(status_ff);
               end else if (id_hit) begin
                  result.read_data = 32'(id_byte(id_offs[5:2]));
               end else begin
                  result.response = RESP_ADDR_ERR;
               end
            end else begin
               priority if (item.address == ADDR_CTRL) begin
                  control_in = item.write_data[3:0];
               end else if (item.address == ADDR_VALUE) begin
                  count_in = write_cnt;
               end else if (item.address == ADDR_RELOAD) begin
                  reload_in = write_cnt;
                  count_in  = write_cnt;
               end else if (item.address == ADDR_INTSTATUS) begin
                  if (item.write_data[0]) begin
                     status_in = 1'b0;
                     int_in    = 1'b0;
                  end
               end else begin
                  result.response = RESP_ADDR_ERR;
               end
            end
         end
         MODE_TICK: begin
            do_count = control_ff[CTL_ENABLE] && !control_ff[CTL_EXT_CLK] &&
                       !(control_ff[CTL_EXT_EN] && !item.ext_level);
         end
         MODE_SAMPLE: begin
            last_ext_in = item.ext_level;
            do_count    = control_ff[CTL_ENABLE] && control_ff[CTL_EXT_CLK] &&
                          item.ext_level && !last_ext_ff;
         end
         MODE_RESET: begin
            control_in  = 4'd0;
            count_in    = '0;
            reload_in   = '0;
            status_in   = 1'b0;
            int_in      = 1'b0;
            last_ext_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (do_count) begin
         if (count_ff == '0) begin
            count_in  = reload_ff;
            status_in = 1'b1;
            if (control_ff[CTL_INT_EN]) begin
               int_in = 1'b1;
            end
         end else begin
            count_in = count_ff - COUNT_BITS'(1);
         end
      end

      result.interrupt_line = int_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= 4'd0;
         count_ff    <= '0;
         reload_ff   <= '0;
         status_ff   <= 1'b0;
         int_ff      <= 1'b0;
         last_ext_ff <= 1'b0;
      end else if (fire) begin
         control_ff  <= control_in;
         count_ff    <= count_in;
         reload_ff   <= reload_in;
         status_ff   <= status_in;
         int_ff      <= int_in;
         last_ext_ff <= last_ext_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rdct_checker.sv]
// ----------------------------------------------------------------------------
// rdct_checker: port-level checks for the reload down-counter timer
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module rdct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic [2:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   import rdct_pkg::*;

   logic req_fire;
   logic req_bus;
   logic req_len_bad;

   assign req_fire    = req_tvalid && req_tready;
   assign req_bus     = (req_tuser == MODE_READ) || (req_tuser == MODE_WRITE);
   assign req_len_bad = (req_tdata[47:44] != LEN_WORD) && (req_tdata[47:44] != LEN_DWORD);

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("no rsp beat after an accepted req beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   a_non_bus_clean: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_bus |=> rsp_tdata[33:0] == 34'd0)
      else $error("non-bus beat returned status or data");

   a_bad_len: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus && req_len_bad |=>
         rsp_tdata[1:0] == RESP_BAD_LEN && rsp_tdata[33:2] == 32'd0)
      else $error("bad length not reported");

   a_soft_reset: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == MODE_RESET |=> !rsp_tdata[34])
      else $error("interrupt high after soft reset");

endmodule

bind reload_down_counter_timer_top rdct_checker u_rdct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
